// ===== src/llda_pkg.sv =====
package llda_pkg;

	// Request kinds carried in s_tuser
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Result status codes carried in m_tuser
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	// Field widths of the stream payloads
	localparam int CFG_W    = 4;
	localparam int ID_W     = 10;
	localparam int STATUS_W = 2;
	localparam int CORE_W   = 3;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_ADD_WRITE,
		ST_RM_CORE,
		ST_RM_READ,
		ST_RM_CMP,
		ST_SH_READ,
		ST_SH_WRITE,
		ST_DONE
	} llda_state_t;

endpackage

// ===== src/llda_ram.sv =====
// Single write port, single registered read port
module llda_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/llda_ctrl.sv =====
// Sequencer: scans list lengths for an add, scans entries and shifts for a remove
module llda_ctrl #(
	parameter int MAX_CORES      = 8,
	parameter int SLOTS_PER_CORE = 16,
	localparam int DEPTH = MAX_CORES * SLOTS_PER_CORE,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1,
	localparam int CCW   = $clog2(MAX_CORES + 1),
	localparam int LW    = $clog2(SLOTS_PER_CORE + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_cmd,
	input  logic [llda_pkg::ID_W-1:0]     req_id,
	input  logic [CCW-1:0]                n_active,
	// result side
	input  logic                          out_free,
	output logic                          res_valid,
	output logic [llda_pkg::STATUS_W-1:0] res_status,
	output logic [llda_pkg::CORE_W-1:0]   res_core,
	// entry store
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [llda_pkg::ID_W-1:0]     ram_wdata,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [llda_pkg::ID_W-1:0]     ram_rdata
);

	llda_pkg::llda_state_t state_q, state_d;

	logic [LW-1:0]                 len_q [MAX_CORES];
	logic [llda_pkg::ID_W-1:0]     id_q;
	logic [CCW-1:0]                core_q;
	logic [AW-1:0]                 base_q;
	logic [LW-1:0]                 slot_q;
	logic [LW-1:0]                 len_cur_q;
	logic [CW-1:0]                 best_q;
	logic [LW-1:0]                 best_len_q;
	logic [AW-1:0]                 best_base_q;
	logic                          found_q;
	logic [llda_pkg::STATUS_W-1:0] status_q;
	logic [llda_pkg::CORE_W-1:0]   res_core_q;

	logic [CW-1:0] core_idx;
	logic [LW-1:0] len_rd;
	logic [LW-1:0] slot_inc;
	logic          core_end;
	logic          slot_end;
	logic          shift_end;
	logic          id_hit;
	logic          len_less;
	logic          req_fire;

	assign core_idx  = core_q[CW-1:0];
	assign len_rd    = len_q[core_idx];
	assign slot_inc  = slot_q + LW'(1);
	assign core_end  = (core_q == n_active);
	assign slot_end  = (slot_q == len_cur_q);
	assign shift_end = (slot_inc == len_cur_q);
	assign id_hit    = (ram_rdata == id_q);
	assign len_less  = (len_rd < best_len_q);
	assign req_fire  = req_valid && req_ready;

	assign res_status = status_q;
	assign res_core   = res_core_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, handshakes and store access
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = best_base_q + AW'(best_len_q);
		ram_wdata = id_q;
		ram_raddr = base_q + AW'(slot_q);
		unique case (state_q)
			llda_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (req_cmd == llda_pkg::CMD_ADD) ? llda_pkg::ST_ADD_SCAN
						: llda_pkg::ST_RM_CORE;
				end
			end
			llda_pkg::ST_ADD_SCAN: begin
				if (core_end) begin
					state_d = found_q ? llda_pkg::ST_ADD_WRITE : llda_pkg::ST_DONE;
				end
			end
			llda_pkg::ST_ADD_WRITE: begin
				ram_we  = 1'b1;
				state_d = llda_pkg::ST_DONE;
			end
			llda_pkg::ST_RM_CORE: begin
				state_d = core_end ? llda_pkg::ST_DONE : llda_pkg::ST_RM_READ;
			end
			llda_pkg::ST_RM_READ: begin
				state_d = slot_end ? llda_pkg::ST_RM_CORE : llda_pkg::ST_RM_CMP;
			end
			llda_pkg::ST_RM_CMP: begin
				state_d = id_hit ? llda_pkg::ST_SH_READ : llda_pkg::ST_RM_READ;
			end
			llda_pkg::ST_SH_READ: begin
				ram_raddr = base_q + AW'(slot_inc);
				state_d   = shift_end ? llda_pkg::ST_DONE : llda_pkg::ST_SH_WRITE;
			end
			llda_pkg::ST_SH_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = base_q + AW'(slot_q);
				ram_wdata = ram_rdata;
				state_d   = llda_pkg::ST_SH_READ;
			end
			llda_pkg::ST_DONE: begin
				res_valid = out_free;
				if (out_free) begin
					state_d = llda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = llda_pkg::ST_IDLE;
			end
		endcase
	end

	// list lengths, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CORES; i++) begin
				len_q[i] <= '0;
			end
		end else if (state_q == llda_pkg::ST_ADD_WRITE) begin
			len_q[best_q] <= best_len_q + LW'(1);
		end else if (state_q == llda_pkg::ST_SH_READ && shift_end) begin
			len_q[core_idx] <= len_cur_q - LW'(1);
		end
	end

	// scan and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			llda_pkg::ST_IDLE: begin
				if (req_fire) begin
					id_q        <= req_id;
					core_q      <= '0;
					base_q      <= '0;
					best_q      <= '0;
					best_base_q <= '0;
					best_len_q  <= LW'(SLOTS_PER_CORE);
					found_q     <= 1'b0;
				end
			end
			llda_pkg::ST_ADD_SCAN: begin
				if (!core_end) begin
					// strict less keeps the lowest-numbered core on a tie
					if (len_less) begin
						best_q      <= core_idx;
						best_len_q  <= len_rd;
						best_base_q <= base_q;
						found_q     <= 1'b1;
					end
					core_q <= core_q + CCW'(1);
					base_q <= base_q + AW'(SLOTS_PER_CORE);
				end else if (!found_q) begin
					status_q   <= llda_pkg::STATUS_FULL;
					res_core_q <= '0;
				end
			end
			llda_pkg::ST_ADD_WRITE: begin
				status_q   <= llda_pkg::STATUS_OK;
				res_core_q <= llda_pkg::CORE_W'(best_q);
			end
			llda_pkg::ST_RM_CORE: begin
				if (core_end) begin
					status_q   <= llda_pkg::STATUS_NOT_FOUND;
					res_core_q <= '0;
				end else begin
					len_cur_q <= len_rd;
					slot_q    <= '0;
				end
			end
			llda_pkg::ST_RM_READ: begin
				if (slot_end) begin
					core_q <= core_q + CCW'(1);
					base_q <= base_q + AW'(SLOTS_PER_CORE);
				end
			end
			llda_pkg::ST_RM_CMP: begin
				if (!id_hit) begin
					slot_q <= slot_inc;
				end
			end
			llda_pkg::ST_SH_READ: begin
				if (shift_end) begin
					status_q   <= llda_pkg::STATUS_OK;
					res_core_q <= llda_pkg::CORE_W'(core_q);
				end
			end
			llda_pkg::ST_SH_WRITE: begin
				slot_q <= slot_inc;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/least_loaded_device_assigner.sv =====
// Least-loaded device assigner. Keeps an ordered list of device ids per worker
// core (core_count cores active, at most MAX_CORES, each list holding up to
// SLOTS_PER_CORE ids). An add request (s_tuser = 0) appends the id to the
// lowest-numbered active core with the shortest list, or answers full; a remove
// request (s_tuser = 1) deletes the first occurrence of the id in the first
// active core that holds it, closing the gap in order, or answers not found.
// Each request gives one result: m_tuser = status (0 ok, 1 full, 2 not found),
// m_tdata = core index, 0 on error. One request is handled at a time, all work
// going through the single entry store: an add compares one list length per
// active core, then writes the id if some list has room; a remove steps through
// the active cores, compares the entries of each list in turn and moves the
// entries after a hit down one place. The result sits in an output register,
// so the next request can be accepted while it waits. core_count must be
// written through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this.
module least_loaded_device_assigner #(
	parameter int MAX_CORES      = 8,
	parameter int SLOTS_PER_CORE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: core_count
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	// request stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [15:0] s_tdata,  // [9:0] device_id, [15:10] zero
	input  logic       s_tuser,   // [0] cmd
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [2:0] core_index, [7:3] zero
	output logic [1:0] m_tuser    // [1:0] status
);

	localparam int DEPTH = MAX_CORES * SLOTS_PER_CORE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CCW   = $clog2(MAX_CORES + 1);

	logic [llda_pkg::CFG_W-1:0]    core_count_q;
	logic [CCW-1:0]                n_active;
	logic                          out_free;
	logic                          res_valid;
	logic [llda_pkg::STATUS_W-1:0] res_status;
	logic [llda_pkg::CORE_W-1:0]   res_core;
	logic                          m_valid_q;
	logic [llda_pkg::STATUS_W-1:0] m_status_q;
	logic [llda_pkg::CORE_W-1:0]   m_core_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [llda_pkg::ID_W-1:0] ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [llda_pkg::ID_W-1:0] ram_rdata;

	// core count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_count_q <= llda_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			core_count_q <= cfg_wdata;
		end
	end

	// active cores, limited to what is built
	assign n_active = (core_count_q > MAX_CORES) ? CCW'(MAX_CORES) : CCW'(core_count_q);

	// result output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_status_q <= res_status;
			m_core_q   <= res_core;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {5'd0, m_core_q};

	llda_ctrl #(
		.MAX_CORES      (MAX_CORES),
		.SLOTS_PER_CORE (SLOTS_PER_CORE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req_cmd    (s_tuser),
		.req_id     (s_tdata[llda_pkg::ID_W-1:0]),
		.n_active   (n_active),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res_status (res_status),
		.res_core   (res_core),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	llda_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (llda_pkg::ID_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== bench/tb_least_loaded_device_assigner.sv =====
module tb_least_loaded_device_assigner;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes and widths shared with the block
	localparam logic       CMD_ADD          = llda_pkg::CMD_ADD;
	localparam logic       CMD_REMOVE       = llda_pkg::CMD_REMOVE;
	localparam logic [1:0] STATUS_OK        = llda_pkg::STATUS_OK;
	localparam logic [1:0] STATUS_FULL      = llda_pkg::STATUS_FULL;
	localparam logic [1:0] STATUS_NOT_FOUND = llda_pkg::STATUS_NOT_FOUND;
	localparam int         CFG_W            = llda_pkg::CFG_W;
	localparam int         ID_W             = llda_pkg::ID_W;
	localparam int         STATUS_W         = llda_pkg::STATUS_W;
	localparam int         CORE_W           = llda_pkg::CORE_W;

	localparam int CORES         = 8;
	localparam int SLOTS         = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 400;
	localparam int PHASES        = 11;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CORE_W-1:0]   core;
	} outcome_t;

	typedef struct packed {
		bit              set_cfg;
		logic [CFG_W-1:0] cfg_val;
		logic            cmd;
		logic [ID_W-1:0] id;
		bit              typed;
		outcome_t        want;
	} step_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [3:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;   // [9:0] device_id, [15:10] zero
	logic        s_tuser   = 1'b0; // [0] cmd
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [2:0] core_index, [7:3] zero
	logic [1:0]  m_tuser;          // [1:0] status

	// Shadow of the per-core id lists
	logic [CFG_W-1:0] active_setting;
	logic [4:0]       core_fill [CORES];
	logic [ID_W-1:0]  core_ids [CORES][SLOTS];

	outcome_t  pending_outcomes [$];
	step_row_t directed_rows [$];
	outcome_t  sink_want;
	int        mismatches  = 0;
	int        cycle_count = 0;
	int        stall_left  = 0;
	bit        steady      = 1'b0;

	least_loaded_device_assigner #(
		.MAX_CORES      (CORES),
		.SLOTS_PER_CORE (SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
		mismatches++;
	endtask

	// Outcome of one request on the shadow lists; updates them as the block would
	function automatic outcome_t place_or_evict(input logic cmd, input logic [ID_W-1:0] id);
		outcome_t res;
		int n;
		int best;
		int best_len;
		int len;
		res.status = STATUS_NOT_FOUND;
		res.core = '0;
		n = (active_setting > CORES) ? CORES : int'(active_setting);
		if (cmd == CMD_ADD) begin
			// lowest-numbered shortest list, full lists never chosen
			best = -1;
			best_len = SLOTS;
			for (int c = 0; c < n; c++) begin
				if (core_fill[c] < best_len) begin
					best = c;
					best_len = core_fill[c];
				end
			end
			if (best < 0) begin
				res.status = STATUS_FULL;
			end else begin
				core_ids[best][best_len] = id;
				core_fill[best] = 5'(best_len + 1);
				res.status = STATUS_OK;
				res.core = best[CORE_W-1:0];
			end
			return res;
		end
		// first active core holding the id; close the gap keeping order
		for (int c = 0; c < n; c++) begin
			len = core_fill[c];
			for (int j = 0; j < len; j++) begin
				if (core_ids[c][j] == id) begin
					for (int k = j; k + 1 < len; k++)
						core_ids[c][k] = core_ids[c][k + 1];
					core_fill[c] = 5'(len - 1);
					res.status = STATUS_OK;
					res.core = c[CORE_W-1:0];
					return res;
				end
			end
		end
		return res;
	endfunction

	function automatic step_row_t row(input bit set_cfg, input int cfg_val, input logic cmd,
			input int id, input bit typed, input logic [STATUS_W-1:0] st, input int core);
		step_row_t r;
		r.set_cfg = set_cfg;
		r.cfg_val = cfg_val[CFG_W-1:0];
		r.cmd = cmd;
		r.id = id[ID_W-1:0];
		r.typed = typed;
		r.want.status = st;
		r.want.core = core[CORE_W-1:0];
		return r;
	endfunction

	// Write core_count once no result is outstanding
	task automatic set_core_count(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		active_setting = value;
		cfg_we <= 1'b0;
	endtask

	// Offer one request, wait for it to be taken, queue its outcome
	task automatic issue_request(input logic cmd, input logic [ID_W-1:0] id, input bit typed,
			input outcome_t typed_want);
		int gap;
		outcome_t predicted;
		gap = 0;
		if (!steady && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(16 - ID_W){1'b0}}, id};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = place_or_evict(cmd, id);
		pending_outcomes.push_back(typed ? typed_want : predicted);
	endtask

	// Result side: check each accepted result, stall in bursts
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				note_mismatch("result with no request pending", m_tuser, -1);
			end else begin
				sink_want = pending_outcomes.pop_front();
				if (m_tuser !== sink_want.status)
					note_mismatch("status", m_tuser, sink_want.status);
				if (m_tdata[CORE_W-1:0] !== sink_want.core)
					note_mismatch("core_index", m_tdata[CORE_W-1:0], sink_want.core);
			end
		end
		if (stall_left > 0)
			stall_left--;
		else if (!steady && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 13);
		m_tready <= arst_n && (stall_left == 0);
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int phase_setting [PHASES];
		int n_items;
		int add_pct;
		int n_act;
		int stored;
		int pick;
		int r;
		bit chosen;
		logic cmd;
		logic [ID_W-1:0] id;
		outcome_t none;

		phase_setting = '{8, 1, 15, 3, 0, 6, 2, -1, 4, 8, -1};
		none = '0;
		active_setting = 4'd1;
		foreach (core_fill[c])
			core_fill[c] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty remove, extremes, duplicates, fill core 0, full, no cores
		directed_rows.push_back(row(1'b0, 0, CMD_REMOVE, 5, 1'b1, STATUS_NOT_FOUND, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_ADD, 0, 1'b1, STATUS_OK, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_ADD, 1023, 1'b1, STATUS_OK, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_ADD, 0, 1'b1, STATUS_OK, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_REMOVE, 0, 1'b1, STATUS_OK, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_REMOVE, 1023, 1'b1, STATUS_OK, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_REMOVE, 1023, 1'b1, STATUS_NOT_FOUND, 0));
		for (int i = 0; i < 15; i++)
			directed_rows.push_back(row(1'b0, 0, CMD_ADD, (i * 331 + 170) % 1024, 1'b1,
				STATUS_OK, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_ADD, 777, 1'b1, STATUS_FULL, 0));
		directed_rows.push_back(row(1'b1, 0, CMD_ADD, 1, 1'b1, STATUS_FULL, 0));
		directed_rows.push_back(row(1'b0, 0, CMD_REMOVE, 0, 1'b1, STATUS_NOT_FOUND, 0));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_cfg)
				set_core_count(directed_rows[i].cfg_val);
			issue_request(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// Random phases, each under its own core count; the last two run without idling
		for (int p = 0; p < PHASES; p++) begin
			steady = (p >= PHASES - 2);
			set_core_count(CFG_W'(phase_setting[p] < 0 ? int'($urandom_range(0, 15))
				: phase_setting[p]));
			n_items = $urandom_range(40, 60);
			add_pct = $urandom_range(35, 75);
			for (int i = 0; i < n_items; i++) begin
				cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_REMOVE;
				r = $urandom_range(0, 9);
				if (r == 0)
					id = '0;
				else if (r == 1)
					id = '1;
				else if (r < 6)
					id = ID_W'($urandom_range(0, 15));
				else
					id = ID_W'($urandom_range(0, 1023));
				// removes mostly target an id that an active list holds
				n_act = (active_setting > CORES) ? CORES : int'(active_setting);
				stored = 0;
				for (int c = 0; c < n_act; c++)
					stored += core_fill[c];
				if (cmd == CMD_REMOVE && stored > 0 && $urandom_range(0, 9) < 7) begin
					pick = $urandom_range(0, stored - 1);
					chosen = 1'b0;
					for (int c = 0; c < n_act && !chosen; c++) begin
						if (pick < core_fill[c]) begin
							id = core_ids[c][pick];
							chosen = 1'b1;
						end else begin
							pick -= core_fill[c];
						end
					end
				end
				issue_request(cmd, id, 1'b0, none);
			end
		end

		// Drain
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/llda_pkg.sv
src/llda_ram.sv
src/llda_ctrl.sv
src/least_loaded_device_assigner.sv
bench/tb_least_loaded_device_assigner.sv
